/* hw/rtl/nms_pkg.sv */
// ----------------------------------------------------------------------------
// nms_pkg: shared types and constants of the natural merge sorter
// Set capacity, data width, the beat passed between sort cells and the
// controller state encoding.
// ----------------------------------------------------------------------------
package nms_pkg;

  // Capacity of one set (legal range 2 to 64)
  localparam int SET_SIZE = 16;
  localparam int DATA_W   = 32;
  // Counter wide enough to hold SET_SIZE itself
  localparam int CNT_W    = $clog2(SET_SIZE + 1);

  // One value travelling along the cell chain
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
  } cell_beat_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_EMIT
  } sort_state_t;

endpackage

/* hw/rtl/natural_merge_sorter_top.sv */
// ----------------------------------------------------------------------------
// natural_merge_sorter_top: sorts sets of signed 32-bit values
// Collects a set through the input channel, sorts it ascending in a chain of
// compare-and-exchange cells and streams it out with the final beat marked.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_value, in_is_last) are taken one per cycle while the
//   block is loading; each beat enters the head cell, and larger values
//   ripple one cell per cycle down the chain of nms_pkg::SET_SIZE cells.
//   Beats beyond SET_SIZE in one set are dropped and flag out_overflow on
//   every result beat of that set.
//   After the beat with in_is_last, in_stall rises and stays high while the
//   last carries drain down the chain and while the sorted set then leaves
//   the head cell at one beat per cycle whenever out_stall is low.
//   A set of n values goes through three phases: load, settle and emit.
//   out_last_out marks the final beat of the set.
//   When out_stall is high while the output register holds a beat, the
//   output register and the chain hold; the block accepts a new set as soon
//   as the last result sits in the output register. Synchronous reset
//   empties the chain, clears the counters and drops any pending result.
// ----------------------------------------------------------------------------
module natural_merge_sorter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [nms_pkg::DATA_W-1:0] in_value,
  input  logic                             in_is_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [nms_pkg::DATA_W-1:0] out_sorted_value,
  output logic                             out_last_out,
  output logic                             out_overflow
);

  localparam int N = nms_pkg::SET_SIZE;

  nms_pkg::sort_state_t state_r, state_nxt;

  logic [nms_pkg::CNT_W-1:0]         fill_r, fill_nxt;
  logic [nms_pkg::CNT_W-1:0]         left_r, left_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [nms_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_ovf_r, out_ovf_nxt;

  logic                             in_accept;
  logic                             store;
  logic                             pop;
  logic                             shift_en;
  logic                             any_carry;

  nms_pkg::cell_beat_t head_in;
  nms_pkg::cell_beat_t own  [N];
  nms_pkg::cell_beat_t cout [N];
  logic [N-1:0]        carry_bits;
  logic [N-1:0]        own_bits;

  // Cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    nms_pkg::cell_beat_t cin_i;
    nms_pkg::cell_beat_t nbr_i;
    if (i == 0) begin : g_head
      assign cin_i = head_in;
    end else begin : g_body
      assign cin_i = cout[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign nbr_i.valid = 1'b0;
      assign nbr_i.value = '0;
    end else begin : g_mid
      assign nbr_i = own[i+1];
    end
    nms_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .cin      (cin_i),
      .nbr      (nbr_i),
      .own      (own[i]),
      .cout     (cout[i])
    );
    assign carry_bits[i] = cout[i].valid;
    assign own_bits[i]   = own[i].valid;
  end

  assign any_carry = |carry_bits;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nms_pkg::ST_LOAD: begin
        if (in_valid && in_is_last) state_nxt = nms_pkg::ST_SETTLE;
      end
      nms_pkg::ST_SETTLE: begin
        if (!any_carry) state_nxt = nms_pkg::ST_EMIT;
      end
      nms_pkg::ST_EMIT: begin
        if (pop && left_r == nms_pkg::CNT_W'(1)) state_nxt = nms_pkg::ST_LOAD;
      end
      default: state_nxt = nms_pkg::ST_LOAD;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    pop      = 1'b0;
    unique case (state_r)
      nms_pkg::ST_LOAD:   in_stall = 1'b0;
      nms_pkg::ST_SETTLE: in_stall = 1'b1;
      nms_pkg::ST_EMIT:   pop = !out_valid_r || !out_stall;
      default:            in_stall = 1'b1;
    endcase
  end

  assign in_accept     = in_valid && !in_stall;
  assign store         = in_accept && (fill_r < nms_pkg::CNT_W'(N));
  assign shift_en      = pop;
  assign head_in.valid = store;
  assign head_in.value = in_value;

  // Counters, overflow flag and output register
  always_comb begin
    fill_nxt      = fill_r;
    left_nxt      = left_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (in_accept) begin
      if (store) fill_nxt = fill_r + nms_pkg::CNT_W'(1);
      else       ovf_nxt  = 1'b1;
      if (in_is_last) left_nxt = store ? fill_r + nms_pkg::CNT_W'(1) : fill_r;
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = own[0].value;
      out_last_nxt  = (left_r == nms_pkg::CNT_W'(1));
      out_ovf_nxt   = ovf_r;
      left_nxt      = left_r - nms_pkg::CNT_W'(1);
      if (left_r == nms_pkg::CNT_W'(1)) begin
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nms_pkg::ST_LOAD;
      fill_r      <= '0;
      left_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      left_r      <= left_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  // Every popped beat comes from an occupied head cell
  a_pop_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> own[0].valid)
    else $error("emit from empty head cell");

  // The chain is empty once the final beat of a set has left
  a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && left_r == nms_pkg::CNT_W'(1)) |=> (own_bits == '0))
    else $error("chain not empty after final beat");

  // No value ever falls off the tail of the chain
  a_no_tail_carry: assert property (@(posedge clk) disable iff (!rst_n)
    !cout[N-1].valid)
    else $error("carry out of the last cell");

  // Fill count stays within capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= nms_pkg::CNT_W'(N))
    else $error("fill count above set size");

endmodule

/* hw/rtl/nms_cell.sv */
// ----------------------------------------------------------------------------
// nms_cell: one stage of the insertion sort chain
// Keeps the smaller of its stored value and the incoming beat and hands the
// larger one to the next cell via a register; shifts toward the head on emit.
// ----------------------------------------------------------------------------
module nms_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  nms_pkg::cell_beat_t cin,
  input  nms_pkg::cell_beat_t nbr,
  output nms_pkg::cell_beat_t own,
  output nms_pkg::cell_beat_t cout
);

  logic                             own_valid_r;
  logic                             own_valid_nxt;
  logic signed [nms_pkg::DATA_W-1:0] own_value_r;
  logic signed [nms_pkg::DATA_W-1:0] own_value_nxt;
  logic                             cout_valid_r;
  logic                             cout_valid_nxt;
  logic signed [nms_pkg::DATA_W-1:0] cout_value_r;
  logic signed [nms_pkg::DATA_W-1:0] cout_value_nxt;

  // Compare and exchange, or shift toward the head on emit
  always_comb begin
    own_valid_nxt  = own_valid_r;
    own_value_nxt  = own_value_r;
    cout_valid_nxt = 1'b0;
    cout_value_nxt = cout_value_r;
    if (shift_en) begin
      own_valid_nxt = nbr.valid;
      own_value_nxt = nbr.value;
    end else if (cin.valid) begin
      if (!own_valid_r) begin
        own_valid_nxt = 1'b1;
        own_value_nxt = cin.value;
      end else if (cin.value < own_value_r) begin
        own_value_nxt  = cin.value;
        cout_valid_nxt = 1'b1;
        cout_value_nxt = own_value_r;
      end else begin
        cout_valid_nxt = 1'b1;
        cout_value_nxt = cin.value;
      end
    end
  end

  // Control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_valid_r  <= 1'b0;
      cout_valid_r <= 1'b0;
    end else begin
      own_valid_r  <= own_valid_nxt;
      cout_valid_r <= cout_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    own_value_r  <= own_value_nxt;
    cout_value_r <= cout_value_nxt;
  end

  assign own.valid  = own_valid_r;
  assign own.value  = own_value_r;
  assign cout.valid = cout_valid_r;
  assign cout.value = cout_value_r;

endmodule
